// File: design/fct_pkg.sv
// Shared types and constants for the frustum cull test core.
`default_nettype none

package fct_pkg;

   localparam int COORD_FIELD_W = 16;   // coordinate port width
   localparam int RADIUS_W      = 15;
   localparam int NORM_W        = 16;   // one packed plane slot, Q2.14 normal or integer w
   localparam int PLANE_W       = 64;   // nx, ny, nz, w
   localparam int W_SLOT        = 3;    // slot of w inside a plane word
   localparam int Q_SHIFT       = 14;   // Q2.14 scale
   localparam int AXES          = 3;
   localparam int CSR_INDEX_W   = 3;

   typedef enum logic [0:0] {
      KIND_BOX    = 1'b0,
      KIND_SPHERE = 1'b1
   } kind_type;

   // One object as it travels down the cell chain; raw port bits.
   typedef struct packed {
      kind_type                                kind;
      logic [AXES-1:0][COORD_FIELD_W-1:0]     lo;
      logic [AXES-1:0][COORD_FIELD_W-1:0]     hi;
      logic [AXES-1:0][COORD_FIELD_W-1:0]     ctr;
      logic [RADIUS_W-1:0]                    radius;
   } obj_type;

   // Beat handed from cell to cell: object plus running verdict.
   typedef struct packed {
      logic    visible;
      obj_type obj;
   } beat_type;

endpackage

`default_nettype wire

// File: design/fct_plane_cell.sv
// One plane cell: holds a plane, tests each passing object against it in two stages.
`default_nettype none

module fct_plane_cell #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cfg_we,
   input  logic [fct_pkg::PLANE_W-1:0] cfg_data,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  fct_pkg::beat_type         in_beat,
   output logic                      out_valid,
   input  logic                      out_ready,
   output fct_pkg::beat_type         out_beat
);
   import fct_pkg::*;

   localparam int PROD_W = NORM_W + COORD_WIDTH;
   localparam int BIAS_W = NORM_W + 1;
   localparam int ACC_W  = ((PROD_W > BIAS_W + Q_SHIFT) ? PROD_W : BIAS_W + Q_SHIFT) + 2;
   localparam int RAW_W  = (COORD_WIDTH > COORD_FIELD_W) ? COORD_WIDTH : COORD_FIELD_W;

   // port bits -> signed COORD_WIDTH value
   function automatic logic signed [COORD_WIDTH-1:0] to_coord(
      input logic [COORD_FIELD_W-1:0] raw
   );
      logic [RAW_W-1:0] wide;
      wide = RAW_W'(raw);
      return signed'(wide[COORD_WIDTH-1:0]);
   endfunction

   logic [PLANE_W-1:0] plane_ff;

   logic                      a_valid_ff;
   logic                      a_ready;
   beat_type                  a_beat_ff;
   logic signed [PROD_W-1:0]  prod_ff [AXES];
   logic signed [BIAS_W-1:0]  bias_ff;

   logic signed [NORM_W-1:0]      norm [AXES];
   logic signed [COORD_WIDTH-1:0] pick [AXES];
   logic signed [PROD_W-1:0]      prod_in [AXES];
   logic signed [NORM_W-1:0]      w_part;
   logic signed [BIAS_W-1:0]      r_term;
   logic signed [BIAS_W-1:0]      bias_in;

   logic                      b_valid_ff;
   logic                      b_ready;
   beat_type                  b_beat_ff;
   beat_type                  b_beat_in;
   logic signed [ACC_W-1:0]   acc_sum;

   // stage a: p-vertex (or center) select and products
   always_comb begin
      for (int k = 0; k < AXES; k++) begin
         norm[k] = signed'(plane_ff[k*NORM_W +: NORM_W]);
         if (in_beat.obj.kind == KIND_SPHERE) begin
            pick[k] = to_coord(in_beat.obj.ctr[k]);
         end else if (!norm[k][NORM_W-1]) begin
            pick[k] = to_coord(in_beat.obj.hi[k]);
         end else begin
            pick[k] = to_coord(in_beat.obj.lo[k]);
         end
         prod_in[k] = norm[k] * pick[k];
      end
   end

   // w + radius folded together; both get the same Q2.14 scale later
   assign w_part  = signed'(plane_ff[W_SLOT*NORM_W +: NORM_W]);
   assign r_term  = (in_beat.obj.kind == KIND_SPHERE) ?
                    signed'(BIAS_W'(in_beat.obj.radius)) : '0;
   assign bias_in = BIAS_W'(w_part) + r_term;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff <= '0;
      end else if (cfg_we) begin
         plane_ff <= cfg_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         a_beat_ff <= in_beat;
         prod_ff   <= prod_in;
         bias_ff   <= bias_in;
      end
   end

   // stage b: exact sum, sign is the cull flag
   assign acc_sum = ACC_W'(prod_ff[0]) + ACC_W'(prod_ff[1]) + ACC_W'(prod_ff[2])
                  + (ACC_W'(bias_ff) <<< Q_SHIFT);

   always_comb begin
      b_beat_in         = a_beat_ff;
      b_beat_in.visible = a_beat_ff.visible & ~acc_sum[ACC_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready && a_valid_ff) begin
         b_beat_ff <= b_beat_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_beat  = b_beat_ff;

endmodule

`default_nettype wire

// File: design/frustum_cull_test_core.sv
// Top level of the frustum cull test core: a chain of plane cells.
//
//  channel | ports                                   | dir | beat
//  --------+-----------------------------------------+-----+------------------------------
//  req     | req_valid/req_ready, req_kind..radius   | in  | one box or sphere object
//  rsp     | rsp_valid/rsp_ready, rsp_visible        | out | one visible bit per object
//  csr     | csr_valid/csr_ready, csr_index, wdata   | in  | one packed plane register
//
// Throughput: one object per cycle while rsp_ready is high. Two register stages per plane
// cell (products, then sum).
// Reset clears every stage valid and loads all planes with zero.
// Stalls: each stage advances when the one after it is empty or moving, so
// bubbles close up and new beats enter while a result waits on rsp_ready.
// csr writes are registered into the addressed cell; csr_ready is always high.
`default_nettype none

module frustum_cull_test_core #(
   parameter int PLANE_COUNT = 6,
   parameter int COORD_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_kind,
   input  logic signed [fct_pkg::COORD_FIELD_W-1:0] req_min_x,
   input  logic signed [fct_pkg::COORD_FIELD_W-1:0] req_min_y,
   input  logic signed [fct_pkg::COORD_FIELD_W-1:0] req_min_z,
   input  logic signed [fct_pkg::COORD_FIELD_W-1:0] req_max_x,
   input  logic signed [fct_pkg::COORD_FIELD_W-1:0] req_max_y,
   input  logic signed [fct_pkg::COORD_FIELD_W-1:0] req_max_z,
   input  logic signed [fct_pkg::COORD_FIELD_W-1:0] req_center_x,
   input  logic signed [fct_pkg::COORD_FIELD_W-1:0] req_center_y,
   input  logic signed [fct_pkg::COORD_FIELD_W-1:0] req_center_z,
   input  logic [fct_pkg::RADIUS_W-1:0]         req_radius,

   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_visible,

   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fct_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [fct_pkg::PLANE_W-1:0]          csr_wdata
);
   import fct_pkg::*;

   // chain[i] feeds cell i; chain[PLANE_COUNT] is the result register
   logic     chain_valid [PLANE_COUNT+1];
   logic     chain_ready [PLANE_COUNT+1];
   beat_type chain_beat  [PLANE_COUNT+1];

   // object enters as visible; each cell may clear the flag
   always_comb begin
      chain_beat[0].visible    = 1'b1;
      chain_beat[0].obj.kind   = kind_type'(req_kind);
      chain_beat[0].obj.lo     = {req_min_z, req_min_y, req_min_x};
      chain_beat[0].obj.hi     = {req_max_z, req_max_y, req_max_x};
      chain_beat[0].obj.ctr    = {req_center_z, req_center_y, req_center_x};
      chain_beat[0].obj.radius = req_radius;
   end

   assign chain_valid[0] = req_valid;
   assign req_ready      = chain_ready[0];

   // writes to unused or nonexistent plane indexes fall on no cell
   assign csr_ready = 1'b1;

   for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_cell
      fct_plane_cell #(
         .COORD_WIDTH(COORD_WIDTH)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cfg_we    (csr_valid && (csr_index == CSR_INDEX_W'(i))),
         .cfg_data  (csr_wdata),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_beat   (chain_beat[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_beat  (chain_beat[i+1])
      );
   end

   assign chain_ready[PLANE_COUNT] = rsp_ready;
   assign rsp_valid   = chain_valid[PLANE_COUNT];
   assign rsp_visible = chain_beat[PLANE_COUNT].visible;

   // input only backs up when the result register is full and stalled
   a_stall_only_from_rsp: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("req_ready low without a stalled result");

   // a ready consumer keeps the whole chain moving
   a_rsp_ready_frees_req: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("req_ready low while rsp_ready high");

   // reset empties the chain
   a_reset_empties: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("chain not empty after reset");

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// Testbench for the frustum cull test core: directed and random objects checked by a predictor.
`timescale 1ns / 100ps

module tb_top;
   import fct_pkg::*;

   localparam int PLANE_COUNT  = 6;
   localparam int COORD_WIDTH  = 16;
   localparam int NUM_PLANES   = 6;
   localparam int Q_ONE        = 1 << Q_SHIFT;
   localparam int LATENCY      = 2 * PLANE_COUNT;
   localparam int SETTLE       = LATENCY + 8;    // quiet cycles after the last result
   localparam int RESET_CYCLES = 5;
   localparam int IDLE_PCT     = 30;
   localparam int STALL_LIMIT  = 2000;           // cycles with no beat on any channel
   localparam int RANDOM_END   = 1580;           // random phases stop here
   localparam int BURST_ITEMS  = 300;

   // plane register index
   localparam logic [CSR_INDEX_W-1:0] PLANE_NEAR   = 3'd4;

   typedef logic [PLANE_W-1:0] plane_word_type;
   typedef plane_word_type plane_set_type [NUM_PLANES];

   typedef enum int {
      SET_BOUNDED,   // unit-ish normals, origin inside
      SET_RAW,       // any 64-bit word
      SET_SPARSE     // bounded, some planes left at zero
   } plane_style_type;

   typedef struct {
      logic visible;
      int   seq;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            req_valid    = 1'b0;
   logic                            req_ready;
   logic                            req_kind     = 1'b0;
   logic signed [COORD_FIELD_W-1:0] req_min_x    = '0;
   logic signed [COORD_FIELD_W-1:0] req_min_y    = '0;
   logic signed [COORD_FIELD_W-1:0] req_min_z    = '0;
   logic signed [COORD_FIELD_W-1:0] req_max_x    = '0;
   logic signed [COORD_FIELD_W-1:0] req_max_y    = '0;
   logic signed [COORD_FIELD_W-1:0] req_max_z    = '0;
   logic signed [COORD_FIELD_W-1:0] req_center_x = '0;
   logic signed [COORD_FIELD_W-1:0] req_center_y = '0;
   logic signed [COORD_FIELD_W-1:0] req_center_z = '0;
   logic [RADIUS_W-1:0]             req_radius   = '0;

   logic                            rsp_valid;
   logic                            rsp_ready    = 1'b0;
   logic                            rsp_visible;

   logic                            csr_valid    = 1'b0;
   logic                            csr_ready;
   logic [CSR_INDEX_W-1:0]          csr_index    = '0;
   logic [PLANE_W-1:0]              csr_wdata    = '0;

   plane_word_type plane_tab [NUM_PLANES] = '{default: '0};   // shadow of the plane registers
   verdict_type    verdict_q [$];                              // predicted verdicts, oldest first
   int             items_sent   = 0;
   int             err_count    = 0;
   int             stall_cycles = 0;
   logic           no_idle      = 1'b0;                        // both sides stream without gaps

   frustum_cull_test_core #(
      .PLANE_COUNT (PLANE_COUNT),
      .COORD_WIDTH (COORD_WIDTH)
   ) u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_kind     (req_kind),
      .req_min_x    (req_min_x),
      .req_min_y    (req_min_y),
      .req_min_z    (req_min_z),
      .req_max_x    (req_max_x),
      .req_max_y    (req_max_y),
      .req_max_z    (req_max_z),
      .req_center_x (req_center_x),
      .req_center_y (req_center_y),
      .req_center_z (req_center_z),
      .req_radius   (req_radius),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_visible  (rsp_visible),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor. Everything is scaled by 2^14 so the Q2.14 normals stay
   // integer; 64-bit sums are exact for 16-bit coordinates.
   // Box: per plane take the p-vertex (max where the normal component is
   // >= 0, min otherwise, even if min > max) and cull on n.p + w < 0.
   // Sphere: cull on n.c + w < -radius.
   // ---------------------------------------------------------------------
   function automatic logic predict_visible(obj_type o);
      longint acc, n, p, lim;
      logic   vis;
      int     i, k;
      vis = 1'b1;
      lim = -(longint'(o.radius) <<< Q_SHIFT);
      for (i = 0; i < PLANE_COUNT; i++) begin
         acc = longint'($signed(plane_tab[i][W_SLOT*NORM_W +: NORM_W])) <<< Q_SHIFT;
         for (k = 0; k < AXES; k++) begin
            n = longint'($signed(plane_tab[i][k*NORM_W +: NORM_W]));
            if (o.kind == KIND_SPHERE) begin
               p = longint'($signed(o.ctr[k]));
            end else if (n >= 0) begin
               p = longint'($signed(o.hi[k]));
            end else begin
               p = longint'($signed(o.lo[k]));
            end
            acc += n * p;
         end
         if (o.kind == KIND_SPHERE ? (acc < lim) : (acc < 0)) begin
            vis = 1'b0;
         end
      end
      return vis;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic plane_word_type pack_plane(int nx, int ny, int nz, int w);
      return {16'(w), 16'(nz), 16'(ny), 16'(nx)};
   endfunction

   // span 0 means the whole signed 16-bit range
   function automatic int rand_val(int span);
      if (span == 0) begin
         return int'($signed(16'($urandom)));
      end
      return int'($urandom_range(2 * span)) - span;
   endfunction

   // Mostly well-ordered boxes; a quarter keep min above max when drawn so.
   // Fields of the other kind are random too since the core must ignore them.
   function automatic obj_type rand_object(int span, int rmax);
      obj_type     o;
      logic [15:0] a, b;
      int          sp, k;
      sp     = ($urandom_range(4) == 0) ? 0 : span;
      o.kind = kind_type'($urandom_range(1));
      for (k = 0; k < AXES; k++) begin
         a = 16'(rand_val(sp));
         b = 16'(rand_val(sp));
         if ($urandom_range(3) != 0 && $signed(a) > $signed(b)) begin
            o.lo[k] = b;
            o.hi[k] = a;
         end else begin
            o.lo[k] = a;
            o.hi[k] = b;
         end
         o.ctr[k] = 16'(rand_val(sp));
      end
      o.radius = ($urandom_range(4) == 0) ? RADIUS_W'($urandom) : RADIUS_W'($urandom_range(rmax));
      return o;
   endfunction

   function automatic obj_type make_box(int lx, int ly, int lz, int hx, int hy, int hz);
      obj_type o;
      o       = rand_object(0, 32767);
      o.kind  = KIND_BOX;
      o.lo[0] = 16'(lx);
      o.lo[1] = 16'(ly);
      o.lo[2] = 16'(lz);
      o.hi[0] = 16'(hx);
      o.hi[1] = 16'(hy);
      o.hi[2] = 16'(hz);
      return o;
   endfunction

   function automatic obj_type make_sphere(int cx, int cy, int cz, int r);
      obj_type o;
      o        = rand_object(0, 32767);
      o.kind   = KIND_SPHERE;
      o.ctr[0] = 16'(cx);
      o.ctr[1] = 16'(cy);
      o.ctr[2] = 16'(cz);
      o.radius = RADIUS_W'(r);
      return o;
   endfunction

   function automatic plane_set_type rand_planes(plane_style_type style);
      plane_set_type s;
      int            i;
      for (i = 0; i < NUM_PLANES; i++) begin
         unique case (style)
            SET_RAW: begin
               s[i] = {$urandom, $urandom};
            end
            SET_SPARSE: begin
               s[i] = ($urandom_range(2) == 0) ? plane_word_type'(0) :
                      pack_plane(rand_val(Q_ONE), rand_val(Q_ONE), rand_val(Q_ONE),
                                 $urandom_range(6000, 500));
            end
            default: begin
               s[i] = pack_plane(rand_val(Q_ONE), rand_val(Q_ONE), rand_val(Q_ONE),
                                 $urandom_range(6000, 500));
            end
         endcase
      end
      return s;
   endfunction

   // ---------------------------------------------------------------------
   // Channel tasks. All start and end at a rising edge. req_valid and
   // csr_valid stay high after a beat so that the next one can follow
   // back to back; whoever stops sending lowers them in that same step.
   // ---------------------------------------------------------------------
   task automatic send_obj(input obj_type o);
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_kind     <= o.kind;
      req_min_x    <= o.lo[0];
      req_min_y    <= o.lo[1];
      req_min_z    <= o.lo[2];
      req_max_x    <= o.hi[0];
      req_max_y    <= o.hi[1];
      req_max_z    <= o.hi[2];
      req_center_x <= o.ctr[0];
      req_center_y <= o.ctr[1];
      req_center_z <= o.ctr[2];
      req_radius   <= o.radius;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      // beat taken at this edge; planes cannot change while objects are in flight
      verdict_q.push_back('{visible: predict_visible(o), seq: items_sent});
      items_sent++;
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input plane_word_type val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      if (idx < NUM_PLANES) begin
         plane_tab[idx] = val;
      end
   endtask

   task automatic load_planes(input plane_set_type words);
      int i;
      for (i = 0; i < NUM_PLANES; i++) begin
         write_csr(CSR_INDEX_W'(i), words[i]);
      end
      csr_valid <= 1'b0;
   endtask

   // Sender holds off until every predicted verdict has come back,
   // then lets the pipeline go quiet.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (verdict_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      err_count++;
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // planes are zero after reset, so nothing may be culled
   task automatic test_zero_planes();
      send_obj(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
      send_obj(make_sphere(-32768, 32767, -32768, 0));
      send_obj(make_sphere(32767, -32768, 32767, 32767));
   endtask

   // axis planes bound the cube [-100, 100]^3; objects on, inside and
   // just outside the faces
   task automatic test_axis_cube();
      plane_set_type cube;
      cube = '{pack_plane( Q_ONE, 0, 0, 100), pack_plane(-Q_ONE, 0, 0, 100),
               pack_plane(0,  Q_ONE, 0, 100), pack_plane(0, -Q_ONE, 0, 100),
               pack_plane(0, 0,  Q_ONE, 100), pack_plane(0, 0, -Q_ONE, 100)};
      wait_idle();
      load_planes(cube);
      send_obj(make_box(-10, -10, -10, 10, 10, 10));
      send_obj(make_box(-300, -10, -10, -101, 10, 10));      // left of the cube
      send_obj(make_box(-300, -10, -10, -100, 10, 10));      // touching: sum is zero
      send_obj(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
      send_obj(make_box(50, 50, 50, -50, -50, -50));         // min above max, still inside
      send_obj(make_box(200, 0, 0, -200, 0, 0));             // min above max, p-vertex outside
      send_obj(make_sphere(-150, 0, 0, 50));                 // touches from outside
      send_obj(make_sphere(-151, 0, 0, 50));                 // one unit too far
      send_obj(make_sphere(0, 0, 0, 0));
      send_obj(make_sphere(200, 200, 200, 32767));
      send_obj(make_sphere(200, 200, 200, 0));
      // a zero near plane must not cull what lies behind it
      wait_idle();
      write_csr(PLANE_NEAR, '0);
      csr_valid <= 1'b0;
      send_obj(make_sphere(0, 0, -5000, 0));
   endtask

   // extreme plane words on every register against extreme objects
   task automatic test_extreme_planes();
      plane_set_type words;
      int            i;
      for (i = 0; i < 3; i++) begin
         unique case (i)
            0:       words = '{default: 64'h8000_8000_8000_8000};
            1:       words = '{default: 64'h7FFF_7FFF_7FFF_7FFF};
            default: words = '{default: '1};
         endcase
         wait_idle();
         load_planes(words);
         send_obj(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
         send_obj(make_sphere(-32768, -32768, -32768, 32767));
      end
   endtask

   // writes past the last plane land nowhere
   task automatic test_bad_index();
      int idx;
      wait_idle();
      load_planes(rand_planes(SET_BOUNDED));
      for (idx = NUM_PLANES; idx < (1 << CSR_INDEX_W); idx++) begin
         write_csr(CSR_INDEX_W'(idx), '1);
      end
      csr_valid <= 1'b0;
      send_obj(make_sphere(0, 0, 0, 0));
      send_obj(make_box(-20, -20, -20, 20, 20, 20));
   endtask

   // phases of random objects, each with a fresh plane set
   task automatic test_random_phases();
      plane_style_type style;
      int              phase, span, rmax;
      phase = 0;
      while (items_sent < RANDOM_END) begin
         style = plane_style_type'(phase % 3);
         span  = (style == SET_RAW) ? 0 : 3000;
         rmax  = (style == SET_RAW) ? 32767 : 2000;
         wait_idle();
         load_planes(rand_planes(style));
         repeat ($urandom_range(140, 60)) send_obj(rand_object(span, rmax));
         phase++;
      end
   endtask

   // long stretch with no gaps on either side
   task automatic test_no_idle_burst();
      wait_idle();
      load_planes(rand_planes(SET_BOUNDED));
      no_idle <= 1'b1;
      repeat (BURST_ITEMS) send_obj(rand_object(3000, 2000));
      no_idle <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Result side: random backpressure, in-order check of each beat
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin : check_visible
      verdict_type v;
      if (!reset && rsp_valid && rsp_ready) begin
         if (verdict_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result, visible %0b", rsp_visible));
         end else begin
            v = verdict_q.pop_front();
            if (rsp_visible !== v.visible) begin
               report_mismatch($sformatf("object %0d: visible %0b, predicted %0b",
                                         v.seq, rsp_visible, v.visible));
            end
         end
      end
   end

   // watchdog: any beat on any channel restarts the count
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout after %0d cycles without a beat", STALL_LIMIT);
         $display("tb_top failed");
         $finish;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_zero_planes();
      test_axis_cube();
      test_extreme_planes();
      test_bad_index();
      test_random_phases();
      test_no_idle_burst();
      wait_idle();
      if (err_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
